// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the trimmed-mean averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define TMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define TMA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tma_pkg.sv =====
// Types and constants shared by the trimmed-mean averager modules.
package tma_pkg;

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 8;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam logic [CNT_W-1:0]    WIN_RESET = 8'd52;
  localparam logic [CNT_W-1:0]    WIN_MIN   = 8'd3;
  localparam logic [CNT_W-1:0]    TRIMMED   = 8'd2;
  localparam logic [SAMPLE_W-1:0] MIN_RESET = 10'd1023;
  localparam logic [SAMPLE_W-1:0] MAX_RESET = 10'd0;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] average;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic complete;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hw/rtl/tma_ctrl.sv =====
// Controller state machine sequencing capture, update, division and output.
`include "assert_macros.svh"

module tma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tma_pkg::dp_status_t st,
  output tma_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = st.complete ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!st.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TMA_ASSERT_NEXT(a_emit_returns_idle, state_r == S_EMIT && !st.out_full,
    state_r == S_IDLE, "Emit did not return the controller to idle.")
  `TMA_ASSERT_NEXT(a_short_item_idle, state_r == S_UPDATE && !st.complete,
    in_ready, "An item without a result did not free the input.")
  `TMA_ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd),
    "More than one datapath command is active.")

endmodule

// ===== hw/rtl/tma_dp.sv =====
// Datapath with per-channel accumulators, serial divider and output register.
`include "assert_macros.svh"

module tma_dp #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tma_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [tma_pkg::CNT_W-1:0]      cfg_wdata,
  input  tma_pkg::ctrl_cmd_t             cmd,
  output tma_pkg::dp_status_t            st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tma_pkg::out_item_t             out_item
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [tma_pkg::SUM_W-1:0]    sum_r [NUM_CHANNELS];
  logic [tma_pkg::CNT_W-1:0]    cnt_r [NUM_CHANNELS];
  logic [tma_pkg::SAMPLE_W-1:0] min_r [NUM_CHANNELS];
  logic [tma_pkg::SAMPLE_W-1:0] max_r [NUM_CHANNELS];

  tma_pkg::in_item_t             item_r;
  logic [tma_pkg::CNT_W-1:0]     window_r;
  logic [tma_pkg::SUM_W-1:0]     quo_r;
  logic [tma_pkg::SUM_W-1:0]     quo_nxt;
  logic [tma_pkg::CNT_W-1:0]     rem_r;
  logic [tma_pkg::CNT_W-1:0]     rem_nxt;
  logic [tma_pkg::CNT_W-1:0]     divisor_r;
  logic [tma_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [tma_pkg::DIV_CNT_W-1:0] div_cnt_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  tma_pkg::out_item_t            out_item_r;

  logic [IDX_W-1:0]              idx;
  logic                          present;
  logic [tma_pkg::SUM_W-1:0]     sum_upd;
  logic [tma_pkg::CNT_W-1:0]     cnt_upd;
  logic [tma_pkg::SAMPLE_W-1:0]  min_upd;
  logic [tma_pkg::SAMPLE_W-1:0]  max_upd;
  logic [tma_pkg::CNT_W-1:0]     win_eff;
  logic [tma_pkg::SUM_W-1:0]     rest;
  logic [tma_pkg::CNT_W:0]       shifted;
  logic [tma_pkg::CNT_W:0]       diff;
  logic                          ge;

  assign idx     = IDX_W'(item_r.channel);
  assign present = int'(item_r.channel) < NUM_CHANNELS;
  assign win_eff = (window_r < tma_pkg::WIN_MIN) ? tma_pkg::WIN_MIN : window_r;

  always_comb begin
    sum_upd = sum_r[idx] + tma_pkg::SUM_W'(item_r.sample);
    cnt_upd = cnt_r[idx] + tma_pkg::CNT_W'(1);
    min_upd = (item_r.sample < min_r[idx]) ? item_r.sample : min_r[idx];
    max_upd = (item_r.sample > max_r[idx]) ? item_r.sample : max_r[idx];
    rest    = sum_upd - tma_pkg::SUM_W'(min_upd) - tma_pkg::SUM_W'(max_upd);
  end

  assign st.complete = present && (cnt_upd >= win_eff);
  assign st.div_done = div_cnt_r == tma_pkg::DIV_CNT_W'(tma_pkg::SUM_W - 1);
  assign st.out_full = out_valid_r && !out_ready;

  // One restoring division step per cycle.
  assign shifted = {rem_r, quo_r[tma_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign ge      = shifted >= {1'b0, divisor_r};

  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.update) begin
      quo_nxt     = rest;
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      quo_nxt     = {quo_r[tma_pkg::SUM_W-2:0], ge};
      rem_nxt     = ge ? diff[tma_pkg::CNT_W-1:0] : shifted[tma_pkg::CNT_W-1:0];
      div_cnt_nxt = div_cnt_r + tma_pkg::DIV_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
        min_r[i] <= tma_pkg::MIN_RESET;
        max_r[i] <= tma_pkg::MAX_RESET;
      end
      window_r    <= tma_pkg::WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update && present) begin
        if (st.complete) begin
          sum_r[idx] <= '0;
          cnt_r[idx] <= '0;
          min_r[idx] <= tma_pkg::MIN_RESET;
          max_r[idx] <= tma_pkg::MAX_RESET;
        end else begin
          sum_r[idx] <= sum_upd;
          cnt_r[idx] <= cnt_upd;
          min_r[idx] <= min_upd;
          max_r[idx] <= max_upd;
        end
      end
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.update) begin
      divisor_r <= cnt_upd - tma_pkg::TRIMMED;
    end
    if (cmd.emit) begin
      out_item_r.out_channel <= item_r.channel;
      out_item_r.average     <= quo_r[tma_pkg::SAMPLE_W-1:0];
    end
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TMA_ASSERT_NEXT(a_window_cleared, cmd.update && st.complete, cnt_r[idx] == '0,
    "A completed window did not clear its channel count.")
  `TMA_ASSERT_IMPL(a_fall_on_ready, $fell(out_valid_r), $past(out_ready),
    "A result was dropped without being taken.")
  `TMA_ASSERT_IMPL(a_emit_free, cmd.emit, !out_valid_r || out_ready,
    "A result overwrote one that was still waiting.")

endmodule

// ===== hw/rtl/trimmed_mean_adc_averager_unit.sv =====
// Top level of the per-channel trimmed-mean ADC averager.
// Each item is one ADC sample tagged with its channel. A sample for a channel at or
// above NUM_CHANNELS is dropped. An item that does not complete a window goes through
// the accept and the accumulator update. An item that completes a window goes through
// the accept, the update, 18 steps of a restoring divider that works one quotient bit
// per cycle, and the load of the output register, which waits while a previous result
// is still held there. The input is ready again as soon as the result is in the output
// register. The window register is written with cfg_we and takes effect for the next
// item; values below three act as three.
module trimmed_mean_adc_averager_unit #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tma_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tma_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [tma_pkg::CNT_W-1:0] cfg_wdata
);

  tma_pkg::ctrl_cmd_t  cmd;
  tma_pkg::dp_status_t st;

  tma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tma_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the per-channel trimmed-mean ADC averager.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH          = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 3000;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  tma_pkg::in_item_t         in_item;
  logic                      out_valid;
  logic                      out_ready;
  tma_pkg::out_item_t        out_item;
  logic                      cfg_we;
  logic [tma_pkg::CNT_W-1:0] cfg_wdata;

  logic [tma_pkg::CNT_W-1:0]    window_reg;
  logic [tma_pkg::SUM_W-1:0]    run_sum [N_CH];
  logic [tma_pkg::CNT_W-1:0]    run_cnt [N_CH];
  logic [tma_pkg::SAMPLE_W-1:0] run_lo  [N_CH];
  logic [tma_pkg::SAMPLE_W-1:0] run_hi  [N_CH];
  tma_pkg::out_item_t           avg_queue [$];

  logic steady;
  int   n_samples;
  int   n_averages;
  int   n_errors;
  int   stall_cycles;

  trimmed_mean_adc_averager_unit #(
    .NUM_CHANNELS(N_CH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [tma_pkg::SAMPLE_W-1:0] rand_sample();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return tma_pkg::SAMPLE_W'($urandom_range(500, 520));
    return tma_pkg::SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  task automatic clear_channel(input int ch);
    run_sum[ch] = '0;
    run_cnt[ch] = '0;
    run_lo[ch]  = tma_pkg::MIN_RESET;
    run_hi[ch]  = tma_pkg::MAX_RESET;
  endtask

  // Accumulates one accepted sample and queues the average when its window closes.
  task automatic track_sample(input tma_pkg::in_item_t it);
    logic [tma_pkg::CNT_W-1:0] eff;
    logic [tma_pkg::SUM_W-1:0] rest;
    logic [tma_pkg::SUM_W-1:0] quot;
    tma_pkg::out_item_t        res;
    int                        ch;
    ch = int'(it.channel);
    if (ch >= N_CH) return;
    eff = (window_reg < tma_pkg::WIN_MIN) ? tma_pkg::WIN_MIN : window_reg;
    run_sum[ch] = run_sum[ch] + tma_pkg::SUM_W'(it.sample);
    run_cnt[ch] = run_cnt[ch] + tma_pkg::CNT_W'(1);
    if (it.sample < run_lo[ch]) run_lo[ch] = it.sample;
    if (it.sample > run_hi[ch]) run_hi[ch] = it.sample;
    if (run_cnt[ch] < eff) return;
    rest = run_sum[ch] - tma_pkg::SUM_W'(run_lo[ch]) - tma_pkg::SUM_W'(run_hi[ch]);
    quot = rest / tma_pkg::SUM_W'(run_cnt[ch] - tma_pkg::TRIMMED);
    res.out_channel = it.channel;
    res.average     = quot[tma_pkg::SAMPLE_W-1:0];
    avg_queue.push_back(res);
    clear_channel(ch);
  endtask

  task automatic send_sample(input logic [tma_pkg::CH_W-1:0] ch,
                             input logic [tma_pkg::SAMPLE_W-1:0] smp);
    tma_pkg::in_item_t item;
    int                gap;
    item.channel = ch;
    item.sample  = smp;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    track_sample(item);
    n_samples++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every queued average has come out and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [tma_pkg::CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = value;
  endtask

  task automatic test_default_window();
    int i;
    for (i = 0; i < 62; i++) begin
      if (i % 6 == 5) send_sample(3'd6, rand_sample());
      else send_sample(3'd5, rand_sample());
    end
    settle();
  endtask

  task automatic test_short_window();
    write_window(8'd0);
    send_sample(3'd0, 10'd0);
    send_sample(3'd7, 10'd1023);
    send_sample(3'd0, 10'd1023);
    send_sample(3'd1, 10'd0);
    send_sample(3'd7, 10'd1023);
    send_sample(3'd1, 10'd0);
    send_sample(3'd0, 10'd1023);
    send_sample(3'd7, 10'd1023);
    send_sample(3'd1, 10'd0);
    settle();
    write_window(8'd1);
    send_sample(3'd4, 10'd1);
    send_sample(3'd4, 10'd2);
    send_sample(3'd4, 10'd3);
    settle();
    write_window(8'd2);
    send_sample(3'd3, 10'd1023);
    send_sample(3'd3, 10'd0);
    send_sample(3'd3, 10'd512);
    settle();
  endtask

  task automatic test_window_lowered();
    write_window(8'd10);
    send_sample(3'd2, 10'd3);
    send_sample(3'd2, 10'd5);
    send_sample(3'd2, 10'd7);
    send_sample(3'd2, 10'd9);
    send_sample(3'd2, 10'd11);
    send_sample(3'd3, 10'd100);
    settle();
    write_window(8'd3);
    send_sample(3'd2, 10'd13);
    send_sample(3'd3, 10'd200);
    send_sample(3'd3, 10'd300);
    settle();
  endtask

  task automatic test_random_windows();
    int phase;
    int i;
    logic [tma_pkg::CNT_W-1:0] win;
    for (phase = 0; phase < 14; phase++) begin
      if (phase == 0) win = 8'd3;
      else if ($urandom_range(0, 5) == 0) win = tma_pkg::CNT_W'($urandom_range(0, 2));
      else win = tma_pkg::CNT_W'($urandom_range(3, 16));
      steady = (phase % 4 == 3);
      write_window(win);
      for (i = 0; i < 100; i++) begin
        if (i == 50 && $urandom_range(0, 1) == 1) begin
          settle();
          write_window(tma_pkg::CNT_W'($urandom_range(0, 16)));
        end
        send_sample(tma_pkg::CH_W'($urandom_range(0, N_CH - 1)), rand_sample());
      end
      settle();
    end
    steady = 1'b0;
  endtask

  task automatic test_long_window();
    int i;
    int r;
    write_window(8'd255);
    for (i = 0; i < 560; i++) begin
      r = int'($urandom_range(0, 15));
      if (r == 0) send_sample(tma_pkg::CH_W'($urandom_range(2, N_CH - 1)), rand_sample());
      else send_sample(tma_pkg::CH_W'(r % 2), rand_sample());
    end
    settle();
    write_window(8'd3);
    for (i = 0; i < N_CH; i++) send_sample(tma_pkg::CH_W'(i), rand_sample());
    settle();
  endtask

  initial begin
    int ch;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    steady     = 1'b0;
    n_samples  = 0;
    window_reg = tma_pkg::WIN_RESET;
    for (ch = 0; ch < N_CH; ch++) clear_channel(ch);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_window();
    test_short_window();
    test_window_lowered();
    test_random_windows();
    test_long_window();
    settle();
    $display("Sent %0d samples and checked %0d trimmed averages over windows from 3 to 255,",
             n_samples, n_averages);
    $display("with short-window clamping, windows lowered mid-window and random stalls.");
    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    int gap;
    int hold;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      hold = int'($urandom_range(1, 8));
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    n_averages = 0;
    n_errors   = 0;
  end

  always @(posedge clk) begin : check_average
    tma_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_averages++;
      if (avg_queue.size() == 0) begin
        $error("unexpected item: out_channel %0d average %0d",
               out_item.out_channel, out_item.average);
        n_errors++;
      end else begin
        want = avg_queue.pop_front();
        if (out_item.out_channel !== want.out_channel) begin
          $error("out_channel mismatch: expected %0d, actual %0d",
                 want.out_channel, out_item.out_channel);
          n_errors++;
        end
        if (out_item.average !== want.average) begin
          $error("average mismatch: expected %0d, actual %0d",
                 want.average, out_item.average);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles without an accepted item.", stall_cycles);
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule

// ===== trimmed_mean_adc_averager_unit.f =====
+incdir+hw/rtl
hw/rtl/tma_pkg.sv
hw/rtl/tma_ctrl.sv
hw/rtl/tma_dp.sv
hw/rtl/trimmed_mean_adc_averager_unit.sv
tb/sv/testbench.sv
